// ===== hw/rtl/tgarle_pkg.sv =====
package tgarle_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_RAWPIX,
        PH_PKTHDR,
        PH_PKTDATA
    } t_phase;

    // Result status codes
    localparam logic [2:0] ST_PIXEL   = 3'd0;
    localparam logic [2:0] ST_HEADER  = 3'd1;
    localparam logic [2:0] ST_ZEROSZ  = 3'd2;
    localparam logic [2:0] ST_BADBPP  = 3'd3;
    localparam logic [2:0] ST_OVERRUN = 3'd4;

    // Data header byte positions
    localparam logic [2:0] HB_WIDTH_LO  = 3'd0;
    localparam logic [2:0] HB_WIDTH_HI  = 3'd1;
    localparam logic [2:0] HB_HEIGHT_LO = 3'd2;
    localparam logic [2:0] HB_HEIGHT_HI = 3'd3;
    localparam logic [2:0] HB_DEPTH     = 3'd4;
    localparam logic [2:0] HB_DESC      = 3'd5;

    // Accepted pixel depths
    localparam logic [7:0] BPP_24 = 8'd24;
    localparam logic [7:0] BPP_32 = 8'd32;

    // Configuration register indexes
    localparam logic REG_RLE_MODE = 1'b0;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        has_alpha;
        logic [7:0]  repeat_count;
        logic        last_pixel;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } t_result;

endpackage

// ===== hw/rtl/tga_rle_pixel_decoder_core.sv =====
// Channel   Direction  Handshake                 Beat
// input     in         i_in_valid / o_in_stall   one file byte plus first-byte flag
// output    out        o_out_valid / i_out_stall  one header, error or pixel result
// config    in         APB write, paddr[2]=0  rle_mode in pwdata[0]
//
// One byte per cycle unless the input stalls: a byte is parsed in the cycle
// it is accepted; any result is in the output register on the next cycle if free.
// The width times height product is one 16x16 multiply on the depth byte.
// Reset (synchronous, active low) idles the parser and sets rle_mode to 1.
// A stalled result parks in a skid entry; input stalls only when both are full.
module tga_rle_pixel_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_has_alpha,
    output logic [7:0]  o_repeat_count,
    output logic        o_last_pixel,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tgarle_pkg::*;

    logic    r_rle_mode;
    logic    step;
    logic    res_valid;
    logic    q_full;
    t_result res;
    t_result q_res;

    assign pready     = 1'b1;
    assign o_in_stall = q_full;
    assign step       = i_in_valid && !q_full;

    // Configuration register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_mode <= 1'b1;
        end else if (psel && penable && pwrite && paddr[2] == REG_RLE_MODE) begin
            r_rle_mode <= pwdata[0];
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_RLE_MODE) begin
            prdata = {31'd0, r_rle_mode};
        end
    end

    tgarle_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (i_data_byte),
        .i_first     (i_first_byte),
        .i_rle_mode  (r_rle_mode),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tgarle_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_full  (q_full),
        .o_res   (q_res)
    );

    assign o_status       = q_res.status;
    assign o_red          = q_res.red;
    assign o_green        = q_res.green;
    assign o_blue         = q_res.blue;
    assign o_alpha        = q_res.alpha;
    assign o_has_alpha    = q_res.has_alpha;
    assign o_repeat_count = q_res.repeat_count;
    assign o_last_pixel   = q_res.last_pixel;
    assign o_image_width  = q_res.image_width;
    assign o_image_height = q_res.image_height;

endmodule

// ===== hw/rtl/tgarle_parser.sv =====
module tgarle_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_first,
    input  logic              i_rle_mode,
    output logic              o_res_valid,
    output tgarle_pkg::t_result o_res
);
    import tgarle_pkg::*;

    t_phase      r_phase, n_phase, e_phase;
    logic [2:0]  r_hidx, n_hidx, e_hidx;
    logic [15:0] r_width, n_width, e_width;
    logic [15:0] r_height, n_height, e_height;
    logic        r_four, n_four;
    logic [31:0] r_left, n_left;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic        r_is_run, n_is_run;
    logic [1:0]  r_bip, n_bip;
    logic [7:0]  r_pix [4];

    logic        pix_done;
    logic        in_pix_phase;
    logic [7:0]  pkt_cnt;
    logic        overrun;
    logic [7:0]  emit_cnt;
    logic        emit_last;
    logic [31:0] left_after;
    logic        size_zero;
    logic        depth_ok;

    // A first flag restarts the header parse
    assign e_phase  = i_first ? PH_HEADER : r_phase;
    assign e_hidx   = i_first ? HB_WIDTH_LO : r_hidx;
    assign e_width  = i_first ? 16'd0 : r_width;
    assign e_height = i_first ? 16'd0 : r_height;

    // Pixel completes on the third or fourth byte
    assign pix_done     = r_four ? (r_bip == 2'd3) : (r_bip == 2'd2);
    assign in_pix_phase = (e_phase == PH_RAWPIX) || (e_phase == PH_PKTDATA);

    // Packet header: low seven bits plus one, for raw and run alike
    assign pkt_cnt = {1'b0, i_byte[6:0]} + 8'd1;
    assign overrun = {24'd0, pkt_cnt} > r_left;

    // Pixels consumed by the result being formed
    assign emit_cnt   = (e_phase == PH_PKTDATA && r_is_run) ? r_pkt_left : 8'd1;
    assign emit_last  = {24'd0, emit_cnt} >= r_left;
    assign left_after = emit_last ? 32'd0 : (r_left - {24'd0, emit_cnt});

    assign size_zero = (e_width == 16'd0) || (e_height == 16'd0);
    assign depth_ok  = (i_byte == BPP_24) || (i_byte == BPP_32);

    // Next state
    always_comb begin
        n_phase    = e_phase;
        n_hidx     = e_hidx;
        n_width    = e_width;
        n_height   = e_height;
        n_four     = r_four;
        n_left     = r_left;
        n_pkt_left = r_pkt_left;
        n_is_run   = r_is_run;
        n_bip      = i_first ? 2'd0 : r_bip;
        unique case (e_phase) inside
            PH_HEADER: begin
                case (e_hidx)
                    HB_WIDTH_LO: begin
                        n_width = {e_width[15:8], i_byte};
                        n_hidx  = HB_WIDTH_HI;
                    end
                    HB_WIDTH_HI: begin
                        n_width = {i_byte, e_width[7:0]};
                        n_hidx  = HB_HEIGHT_LO;
                    end
                    HB_HEIGHT_LO: begin
                        n_height = {e_height[15:8], i_byte};
                        n_hidx   = HB_HEIGHT_HI;
                    end
                    HB_HEIGHT_HI: begin
                        n_height = {i_byte, e_height[7:0]};
                        n_hidx   = HB_DEPTH;
                    end
                    HB_DEPTH: begin
                        n_four = (i_byte == BPP_32);
                        if (size_zero || !depth_ok) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_left = {16'd0, e_width} * {16'd0, e_height};
                            n_hidx = HB_DESC;
                        end
                    end
                    default: begin
                        // Skip descriptor, start pixel data
                        n_hidx  = HB_WIDTH_LO;
                        n_bip   = 2'd0;
                        n_phase = i_rle_mode ? PH_PKTHDR : PH_RAWPIX;
                    end
                endcase
            end
            PH_PKTHDR: begin
                if (overrun) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_pkt_left = pkt_cnt;
                    n_is_run   = i_byte[7];
                    n_bip      = 2'd0;
                    n_phase    = PH_PKTDATA;
                end
            end
            PH_RAWPIX, PH_PKTDATA: begin
                if (pix_done) begin
                    n_bip  = 2'd0;
                    n_left = left_after;
                    if (e_phase == PH_PKTDATA) begin
                        n_pkt_left = r_is_run ? 8'd0 : (r_pkt_left - 8'd1);
                    end
                    if (emit_last) begin
                        n_phase = PH_IDLE;
                    end else if (e_phase == PH_PKTDATA
                                 && (r_is_run || r_pkt_left == 8'd1)) begin
                        n_phase = PH_PKTHDR;
                    end
                end else begin
                    n_bip = r_bip + 2'd1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Result
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (e_phase) inside
            PH_HEADER: begin
                if (e_hidx == HB_DEPTH) begin
                    o_res_valid        = 1'b1;
                    o_res.has_alpha    = (i_byte == BPP_32);
                    o_res.image_width  = e_width;
                    o_res.image_height = e_height;
                    if (size_zero) begin
                        o_res.status = ST_ZEROSZ;
                    end else if (!depth_ok) begin
                        o_res.status = ST_BADBPP;
                    end else begin
                        o_res.status = ST_HEADER;
                    end
                end
            end
            PH_PKTHDR: begin
                if (overrun) begin
                    o_res_valid  = 1'b1;
                    o_res.status = ST_OVERRUN;
                end
            end
            PH_RAWPIX, PH_PKTDATA: begin
                if (pix_done) begin
                    o_res_valid        = 1'b1;
                    o_res.status       = ST_PIXEL;
                    o_res.blue         = r_pix[0];
                    o_res.green        = r_pix[1];
                    o_res.red          = r_four ? r_pix[2] : i_byte;
                    o_res.alpha        = r_four ? i_byte : 8'd0;
                    o_res.has_alpha    = r_four;
                    o_res.repeat_count = emit_cnt;
                    o_res.last_pixel   = emit_last;
                end
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
        if (!i_step) begin
            o_res_valid = 1'b0;
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_hidx     <= HB_WIDTH_LO;
            r_width    <= '0;
            r_height   <= '0;
            r_four     <= 1'b0;
            r_left     <= '0;
            r_pkt_left <= '0;
            r_is_run   <= 1'b0;
            r_bip      <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_hidx     <= n_hidx;
            r_width    <= n_width;
            r_height   <= n_height;
            r_four     <= n_four;
            r_left     <= n_left;
            r_pkt_left <= n_pkt_left;
            r_is_run   <= n_is_run;
            r_bip      <= n_bip;
        end
    end

    // Gather pixel bytes
    always_ff @(posedge i_clk) begin
        if (i_step && in_pix_phase && !pix_done) begin
            r_pix[r_bip] <= i_byte;
        end
    end

endmodule

// ===== hw/rtl/tgarle_outq.sv =====
module tgarle_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tgarle_pkg::t_result i_res,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_full,
    output tgarle_pkg::t_result o_res
);
    import tgarle_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    pop;

    assign pop     = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_full  = r_skid_valid;
    assign o_res   = r_out;

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Move payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

endmodule

// ===== hw/rtl/tgarle_checker.sv =====
module tgarle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic [7:0]  o_alpha,
    input logic [7:0]  o_repeat_count,
    input logic        o_last_pixel,
    input logic        o_has_alpha,
    input logic [15:0] o_image_width
);
    import tgarle_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_repeat_count) && $stable(o_red))
        else $error("stalled result changed");

    // Input stalls only behind a held result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // Pixels carry a repeat count in 1..128 and no image width
    a_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_PIXEL |->
            o_repeat_count != 8'd0 && o_repeat_count <= 8'd128 && o_image_width == 16'd0)
        else $error("bad pixel repeat count");

    // Non-pixel results carry no color, no count and no last-pixel flag
    a_nonpix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_PIXEL |->
            o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0 && o_alpha == 8'd0
            && o_repeat_count == 8'd0 && !o_last_pixel)
        else $error("non-pixel result with pixel data");

    // Overrun carries nothing else
    a_ovr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OVERRUN |-> !o_has_alpha && o_image_width == 16'd0)
        else $error("overrun result not clean");

endmodule

bind tga_rle_pixel_decoder_core tgarle_checker u_tgarle_checker (.*);
